/* hdl/erpm_pkg.sv */
// Shared types, widths and constants of the encoder rpm estimator.
package erpm_pkg;

  // Field and register widths.
  localparam int ANG_W      = 14;
  localparam int FRAME_W    = 16;
  localparam int TS_W       = 32;
  localparam int DT_W       = 31;
  localparam int RPM_W      = 34;
  localparam int ALPHA_W    = 16;
  localparam int POLE_W     = 8;
  localparam int CNT_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Frame layout.
  localparam int ERR_BIT = 14;

  // Numerator arithmetic: magnitude times microseconds per minute, then Q.8.
  localparam int MAG_W     = 14;
  localparam int US_W      = 26;
  localparam int FRAC_BITS = 8;
  localparam int NUM_W     = MAG_W + US_W + FRAC_BITS;

  localparam logic [US_W-1:0]  US_PER_MIN = US_W'(60000000);
  localparam logic [RPM_W-1:0] RPM_LIMIT  = RPM_W'(64'd7680000000);

  // Bad frame counter limit.
  localparam logic [CNT_W-1:0] ERR_LIMIT = CNT_W'(10);

  // Register reset values.
  localparam logic [POLE_W-1:0]  POLE_RESET  = POLE_W'(1);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLES     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LPF_ALPHA = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_RPM    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FIRST  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONPOS = 2'd3;

  // Status of the iterative divider.
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

/* hdl/erpm_div.sv */
// Iterative restoring divider, one quotient bit per cycle, with overflow flag.
module erpm_div import erpm_pkg::*; #(
  parameter int NUM_W_P = 48,
  parameter int DEN_W_P = 56,
  parameter int Q_W_P   = 34
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W_P-1:0] num_i,
  input  logic [DEN_W_P-1:0] den_i,
  output logic [Q_W_P-1:0]   quot_o,
  output div_stat_t          stat_o
);

  localparam int CW = $clog2(NUM_W_P + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [NUM_W_P-1:0] num_q, num_d;
  logic [DEN_W_P-1:0] den_q, den_d;
  logic [DEN_W_P-1:0] rem_q, rem_d;
  logic [Q_W_P-1:0]   quot_q, quot_d;
  logic               ovf_q, ovf_d;
  logic [DEN_W_P:0]   trial;
  logic [DEN_W_P:0]   diff;
  logic               ge;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem_q, num_q[NUM_W_P-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Sequencing of the division steps.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NUM_W_P);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DEN_W_P-1:0] : trial[DEN_W_P-1:0];
      num_d  = {num_q[NUM_W_P-2:0], 1'b0};
      quot_d = {quot_q[Q_W_P-2:0], ge};
      ovf_d  = ovf_q | quot_q[Q_W_P-1];
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign quot_o      = quot_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

/* hdl/encoder_frame_rpm_estimator_core.sv */
// Top level of the encoder rpm estimator: frame check, sequencer, divider and filter.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   input    | in_valid_i / in_ready_o    | frame_i, timestamp_us_i
//   result   | out_valid_o / out_ready_i  | status_o, angle_o, raw_rpm_o,
//            |                            | filtered_rpm_o, error_burst_o
//   config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A rejected frame, a first sample or a non-positive time step goes from S_EVAL straight
// to S_OUT, and the next request is taken once the sequencer is back in S_IDLE.
// A published rpm runs through S_MUL, S_DEN, S_DIV, S_FLT1 and S_FLT2, and S_FLT3 and
// S_FLT4 on standstill; S_DIV spans the divider's 48 quotient steps, one per cycle.
// Asynchronous active-low reset returns the state and the control and model registers to their defaults.
// One request is in flight at a time; a result waiting at the output stalls only the
// completion of the next request, and configuration writes are always taken.
module encoder_frame_rpm_estimator_core import erpm_pkg::*; #(
  parameter int ANGLE_STEPS = 16384
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [FRAME_W-1:0]          frame_i,
  input  logic [TS_W-1:0]             timestamp_us_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [STATUS_W-1:0]         status_o,
  output logic [ANG_W-1:0]            angle_o,
  output logic signed [RPM_W-1:0]     raw_rpm_o,
  output logic signed [RPM_W-1:0]     filtered_rpm_o,
  output logic                        error_burst_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int STEP_W  = $clog2(ANGLE_STEPS + 1);
  localparam int DW      = ((STEP_W > 15) ? STEP_W : 15) + 2;
  localparam int HALF    = ANGLE_STEPS / 2;
  localparam int DTP_W   = DT_W + POLE_W;
  localparam int DEN_W   = DTP_W + STEP_W;
  localparam int MP_W    = MAG_W + US_W;
  localparam int MB_W    = RPM_W + 1;
  localparam int PROD_W  = ALPHA_W + 1 + MB_W;
  localparam int STEPS_W = PROD_W - ALPHA_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DEN  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_FLT1 = 4'd5;
  localparam logic [3:0] S_FLT2 = 4'd6;
  localparam logic [3:0] S_FLT3 = 4'd7;
  localparam logic [3:0] S_FLT4 = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]               state_q, state_d;
  logic                     out_valid_q, out_valid_d;
  logic [POLE_W-1:0]        pole_q, pole_d;
  logic [ALPHA_W-1:0]       alpha_q, alpha_d;
  logic                     awaiting_q, awaiting_d;
  logic [CNT_W-1:0]         bad_cnt_q, bad_cnt_d;
  logic [ANG_W-1:0]         last_angle_q, last_angle_d;
  logic [TS_W-1:0]          last_time_q, last_time_d;
  logic signed [RPM_W-1:0]  est_q, est_d;

  logic [FRAME_W-1:0]       frame_q, frame_d;
  logic [TS_W-1:0]          ts_q, ts_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic                     zero_q, zero_d;
  logic [DT_W-1:0]          dt_q, dt_d;
  logic [NUM_W-1:0]         num_q, num_d;
  logic [DTP_W-1:0]         dtp_q, dtp_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [STATUS_W-1:0]      res_status_q, res_status_d;
  logic [ANG_W-1:0]         res_angle_q, res_angle_d;
  logic signed [RPM_W-1:0]  res_raw_q, res_raw_d;
  logic                     res_burst_q, res_burst_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;
  logic [ANG_W-1:0]         out_angle_q, out_angle_d;
  logic signed [RPM_W-1:0]  out_raw_q, out_raw_d;
  logic signed [RPM_W-1:0]  out_filt_q, out_filt_d;
  logic                     out_burst_q, out_burst_d;

  logic                     frame_ok;
  logic [ANG_W-1:0]         ang;
  logic [TS_W-1:0]          tdiff;
  logic signed [DW-1:0]     delta_raw;
  logic signed [DW-1:0]     delta;
  logic [DW-1:0]            delta_abs;
  logic [CNT_W-1:0]         cnt_inc;
  logic [POLE_W-1:0]        poles;
  logic [MP_W-1:0]          mag_prod;
  logic [DEN_W-1:0]         den;
  logic                     div_start;
  logic [RPM_W-1:0]         quot;
  div_stat_t                div_stat;
  logic [RPM_W-1:0]         q_sat;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [STEPS_W-1:0] filt_step;
  logic signed [STEPS_W-1:0] est_ext;
  logic signed [STEPS_W-1:0] est_sum;
  logic                     out_free;

  // Frame check and angle delta against the stored sample.
  assign frame_ok  = ~(^frame_q) & ~frame_q[ERR_BIT];
  assign ang       = frame_q[ANG_W-1:0];
  assign tdiff     = ts_q - last_time_q;
  assign delta_raw = $signed(DW'(ang)) - $signed(DW'(last_angle_q));
  assign cnt_inc   = bad_cnt_q + CNT_W'(1);

  always_comb begin
    if (delta_raw > $signed(DW'(HALF))) begin
      delta = delta_raw - $signed(DW'(ANGLE_STEPS));
    end else if (delta_raw < -$signed(DW'(HALF))) begin
      delta = delta_raw + $signed(DW'(ANGLE_STEPS));
    end else begin
      delta = delta_raw;
    end
  end

  assign delta_abs = delta[DW-1] ? DW'(-delta) : DW'(delta);

  // Numerator and denominator products for the rpm quotient.
  assign poles    = (pole_q == '0) ? POLE_W'(1) : pole_q;
  assign mag_prod = MP_W'(mag_q) * MP_W'(US_PER_MIN);
  assign den      = DEN_W'(dtp_q) * DEN_W'(ANGLE_STEPS);

  // Iterative divider for the rpm quotient.
  assign div_start = (state_q == S_DEN);

  erpm_div #(
    .NUM_W_P (NUM_W),
    .DEN_W_P (DEN_W),
    .Q_W_P   (RPM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  assign q_sat = (div_stat.ovf || (quot > RPM_LIMIT)) ? RPM_LIMIT : quot;

  // Filter multiplier, shared between the tracking step and the decay step.
  assign mul_b     = (state_q == S_FLT1) ? ($signed({res_raw_q[RPM_W-1], res_raw_q}) -
                                            $signed({est_q[RPM_W-1], est_q}))
                                         : $signed({est_q[RPM_W-1], est_q});
  assign mul_p     = $signed({1'b0, alpha_q}) * mul_b;
  assign filt_step = $signed(prod_q[PROD_W-1:ALPHA_W]);
  assign est_ext   = $signed(STEPS_W'(est_q));
  assign est_sum   = (state_q == S_FLT2) ? (est_ext + filt_step) : (est_ext - filt_step);

  assign out_free = ~out_valid_q | out_ready_i;

  // Sequencer and state updates.
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    pole_d       = pole_q;
    alpha_d      = alpha_q;
    awaiting_d   = awaiting_q;
    bad_cnt_d    = bad_cnt_q;
    last_angle_d = last_angle_q;
    last_time_d  = last_time_q;
    est_d        = est_q;
    frame_d      = frame_q;
    ts_d         = ts_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    zero_d       = zero_q;
    dt_d         = dt_q;
    num_d        = num_q;
    dtp_d        = dtp_q;
    prod_d       = prod_q;
    res_status_d = res_status_q;
    res_angle_d  = res_angle_q;
    res_raw_d    = res_raw_q;
    res_burst_d  = res_burst_q;
    out_status_d = out_status_q;
    out_angle_d  = out_angle_q;
    out_raw_d    = out_raw_q;
    out_filt_d   = out_filt_q;
    out_burst_d  = out_burst_q;

    // Result register drains independently of the sequencer.
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Configuration writes.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_POLES:     pole_d  = cfg_data_i[POLE_W-1:0];
        REG_LPF_ALPHA: alpha_d = cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          frame_d = frame_i;
          ts_d    = timestamp_us_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_raw_d   = '0;
        res_burst_d = 1'b0;
        res_angle_d = '0;
        state_d     = S_OUT;
        if (!frame_ok) begin
          res_status_d = ST_ERROR;
          if (cnt_inc > ERR_LIMIT) begin
            bad_cnt_d   = '0;
            res_burst_d = 1'b1;
          end else begin
            bad_cnt_d = cnt_inc;
          end
        end else begin
          bad_cnt_d    = '0;
          res_angle_d  = ang;
          last_angle_d = ang;
          last_time_d  = ts_q;
          mag_d        = delta_abs[MAG_W-1:0];
          neg_d        = delta[DW-1];
          zero_d       = (delta == '0);
          dt_d         = tdiff[DT_W-1:0];
          if (awaiting_q) begin
            res_status_d = ST_FIRST;
            awaiting_d   = 1'b0;
          end else if (tdiff[TS_W-1] || (tdiff == '0)) begin
            res_status_d = ST_NONPOS;
          end else begin
            res_status_d = ST_RPM;
            state_d      = S_MUL;
          end
        end
      end
      S_MUL: begin
        num_d   = {mag_prod, FRAC_BITS'(0)};
        dtp_d   = DTP_W'(dt_q) * DTP_W'(poles);
        state_d = S_DEN;
      end
      S_DEN: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_raw_d = neg_q ? $signed(-q_sat) : $signed(q_sat);
          state_d   = S_FLT1;
        end
      end
      S_FLT1: begin
        prod_d  = mul_p;
        state_d = S_FLT2;
      end
      S_FLT2: begin
        est_d   = est_sum[RPM_W-1:0];
        state_d = zero_q ? S_FLT3 : S_OUT;
      end
      S_FLT3: begin
        prod_d  = mul_p;
        state_d = S_FLT4;
      end
      S_FLT4: begin
        est_d   = est_sum[RPM_W-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_angle_d  = res_angle_q;
          out_raw_d    = res_raw_q;
          out_filt_d   = est_q;
          out_burst_d  = res_burst_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and model state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      pole_q       <= POLE_RESET;
      alpha_q      <= ALPHA_RESET;
      awaiting_q   <= 1'b1;
      bad_cnt_q    <= '0;
      last_angle_q <= '0;
      last_time_q  <= '0;
      est_q        <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pole_q       <= pole_d;
      alpha_q      <= alpha_d;
      awaiting_q   <= awaiting_d;
      bad_cnt_q    <= bad_cnt_d;
      last_angle_q <= last_angle_d;
      last_time_q  <= last_time_d;
      est_q        <= est_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    frame_q      <= frame_d;
    ts_q         <= ts_d;
    mag_q        <= mag_d;
    neg_q        <= neg_d;
    zero_q       <= zero_d;
    dt_q         <= dt_d;
    num_q        <= num_d;
    dtp_q        <= dtp_d;
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_angle_q  <= res_angle_d;
    res_raw_q    <= res_raw_d;
    res_burst_q  <= res_burst_d;
    out_status_q <= out_status_d;
    out_angle_q  <= out_angle_d;
    out_raw_q    <= out_raw_d;
    out_filt_q   <= out_filt_d;
    out_burst_q  <= out_burst_d;
  end

  // Port outputs.
  assign in_ready_o     = (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign angle_o        = out_angle_q;
  assign raw_rpm_o      = out_raw_q;
  assign filtered_rpm_o = out_filt_q;
  assign error_burst_o  = out_burst_q;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the encoder rpm estimator: directed table, then random phases.
module tb_top import erpm_pkg::*; ();

  localparam int ANGLE_STEPS = 16384;
  localparam int HALF_TURN = ANGLE_STEPS / 2;
  localparam longint unsigned US_PER_MINUTE = 60000000;
  localparam longint unsigned Q8_ONE = 256;
  localparam longint RPM_CLAMP = 64'sd7680000000;
  localparam int Q16_SHIFT = 16;
  localparam int POLES_AT_RESET = 1;
  localparam int ALPHA_AT_RESET = 6554;
  localparam int IDLE_PCT = 32;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_LEN = 200;

  // One result as seen on the output port.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ANG_W-1:0]    angle;
    logic [RPM_W-1:0]    raw;
    logic [RPM_W-1:0]    filt;
    logic                burst;
  } speed_result_t;

  // One row of the directed table.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [TS_W-1:0]    ts;
    logic               typed;
    speed_result_t      want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [FRAME_W-1:0]      frame_i;
  logic [TS_W-1:0]         timestamp_us_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [STATUS_W-1:0]     status_o;
  logic [ANG_W-1:0]        angle_o;
  logic signed [RPM_W-1:0] raw_rpm_o;
  logic signed [RPM_W-1:0] filtered_rpm_o;
  logic                    error_burst_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  // Predicted state and registers of the estimator.
  logic [ANG_W-1:0]   prev_angle;
  logic [TS_W-1:0]    prev_time;
  bit                 awaiting_first;
  longint             est_q8;
  logic [CNT_W-1:0]   bad_frames;
  logic [POLE_W-1:0]  pole_count;
  logic [ALPHA_W-1:0] alpha;

  speed_result_t pending_results[$];
  stim_row_t     stim_table[$];
  int            mismatch_count;
  bit            steady_flow;

  // Cursor of the random generator: where the shaft was last sent.
  logic [ANG_W-1:0] gen_angle;
  logic [TS_W-1:0]  gen_time;
  int               bad_run;

  encoder_frame_rpm_estimator_core #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_i        (frame_i),
    .timestamp_us_i (timestamp_us_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .angle_o        (angle_o),
    .raw_rpm_o      (raw_rpm_o),
    .filtered_rpm_o (filtered_rpm_o),
    .error_burst_o  (error_burst_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Works out the result of one accepted request and advances the predicted state.
  function automatic speed_result_t estimate_speed(input logic [FRAME_W-1:0] frame,
                                                   input logic [TS_W-1:0] ts);
    speed_result_t     res;
    logic [TS_W-1:0]   diff;
    longint            dt;
    longint            delta;
    longint            raw;
    longint            a;
    longint unsigned   mag;
    longint unsigned   quo;
    longint unsigned   poles;
    res = '0;
    if ((^frame) || frame[ERR_BIT]) begin
      res.status = ST_ERROR;
      bad_frames = bad_frames + 1'b1;
      if (bad_frames > ERR_LIMIT) begin
        bad_frames = '0;
        res.burst = 1'b1;
      end
    end else begin
      bad_frames = '0;
      res.angle = frame[ANG_W-1:0];
      diff = ts - prev_time;
      dt = longint'($signed(diff));
      if (awaiting_first) begin
        res.status = ST_FIRST;
        awaiting_first = 1'b0;
      end else if (dt <= 0) begin
        res.status = ST_NONPOS;
      end else begin
        // Shortest path round the circle; exactly half a turn keeps its sign.
        delta = longint'(res.angle) - longint'(prev_angle);
        if (delta > HALF_TURN) begin
          delta -= ANGLE_STEPS;
        end else if (delta < -HALF_TURN) begin
          delta += ANGLE_STEPS;
        end
        mag = (delta < 0) ? -delta : delta;
        poles = (pole_count == '0) ? 64'd1 : 64'(pole_count);
        quo = (mag * US_PER_MINUTE * Q8_ONE) / (ANGLE_STEPS * dt * poles);
        if (quo > RPM_CLAMP) begin
          quo = RPM_CLAMP;
        end
        raw = (delta < 0) ? -$signed(quo) : $signed(quo);
        // Low-pass step, with a further decay while the shaft stands still.
        a = longint'(alpha);
        est_q8 += (a * (raw - est_q8)) >>> Q16_SHIFT;
        if (delta == 0) begin
          est_q8 -= (a * est_q8) >>> Q16_SHIFT;
        end
        res.status = ST_RPM;
        res.raw = raw[RPM_W-1:0];
      end
      prev_angle = res.angle;
      prev_time = ts;
    end
    res.filt = est_q8[RPM_W-1:0];
    return res;
  endfunction

  // A frame with even parity and the error bit clear.
  function automatic logic [FRAME_W-1:0] good_frame(input logic [ANG_W-1:0] ang);
    return {^ang, 1'b0, ang};
  endfunction

  function automatic void add_row(input logic [FRAME_W-1:0] frame, input logic [TS_W-1:0] ts,
                                  input logic typed, input logic [STATUS_W-1:0] status,
                                  input logic [ANG_W-1:0] ang, input logic burst);
    stim_row_t row;
    row.frame = frame;
    row.ts = ts;
    row.typed = typed;
    row.want = '0;
    row.want.status = status;
    row.want.angle = ang;
    row.want.burst = burst;
    stim_table.push_back(row);
  endfunction

  // Offers one request, waits for it to be taken and records what should come back.
  task automatic send_sample(input logic [FRAME_W-1:0] frame, input logic [TS_W-1:0] ts,
                             input logic typed, input speed_result_t want);
    speed_result_t got;
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      if ($urandom_range(99) == 0) begin
        while (pending_results.size() != 0) @(negedge clk);
      end
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    frame_i <= frame;
    timestamp_us_i <= ts;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    got = estimate_speed(frame, ts);
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // Leaves the write request raised; the caller drops it after the last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    if (idx == REG_POLES) begin
      pole_count = data[POLE_W-1:0];
    end else begin
      alpha = data;
    end
    @(negedge clk);
  endtask

  // Lets the block drain, then loads both registers.
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] pole_data,
                                input logic [CFG_DATA_W-1:0] alpha_data);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_register(REG_POLES, pole_data);
    write_register(REG_LPF_ALPHA, alpha_data);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly a plausibly turning shaft, with rejected frames, bursts of them and time slips.
  task automatic send_random_samples(input int count);
    logic [FRAME_W-1:0] frame;
    logic [ANG_W-1:0]   ang;
    logic [TS_W-1:0]    ts;
    int                 pick;
    int                 dt_pick;
    speed_result_t      no_result;
    no_result = '0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (bad_run == 0 && pick < 2) begin
        bad_run = $urandom_range(13, 10);
      end
      if (bad_run > 0 || pick < 10) begin
        if (bad_run > 0) begin
          bad_run--;
        end
        frame = FRAME_W'($urandom_range(16'hFFFF, 0));
        if (!(^frame) && !frame[ERR_BIT]) begin
          frame[FRAME_W-1] = ~frame[FRAME_W-1];
        end
        ts = $urandom;
      end else begin
        case ($urandom_range(2))
          0: ang = gen_angle;
          1: ang = gen_angle + ANG_W'($urandom_range(600)) - ANG_W'(300);
          default: ang = ANG_W'($urandom_range(ANGLE_STEPS - 1));
        endcase
        if (pick < 13) begin
          ts = gen_time;
        end else if (pick < 18) begin
          ts = gen_time + 32'h8000_0000 + $urandom_range(32'h7FFF_FFFF, 0);
        end else begin
          dt_pick = $urandom_range(99);
          if (dt_pick < 60) begin
            ts = gen_time + $urandom_range(3000, 1);
          end else if (dt_pick < 80) begin
            ts = gen_time + $urandom_range(8, 1);
          end else begin
            ts = gen_time + $urandom_range(32'h7FFF_FFFF, 1);
          end
        end
        frame = good_frame(ang);
        gen_angle = ang;
        gen_time = ts;
      end
      send_sample(frame, ts, 1'b0, no_result);
    end
  endtask

  // Result side: back-pressure at random except during the steady stretch.
  always @(negedge clk) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compares each accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin
    speed_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d angle %0d", status_o, angle_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (angle_o !== want.angle) begin
          $error("angle: expected %0d, got %0d", want.angle, angle_o);
          mismatch_count++;
        end
        if (raw_rpm_o !== want.raw) begin
          $error("raw_rpm: expected %0d, got %0d", $signed(want.raw), raw_rpm_o);
          mismatch_count++;
        end
        if (filtered_rpm_o !== want.filt) begin
          $error("filtered_rpm: expected %0d, got %0d", $signed(want.filt), filtered_rpm_o);
          mismatch_count++;
        end
        if (error_burst_o !== want.burst) begin
          $error("error_burst: expected %0d, got %0d", want.burst, error_burst_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    #12000000;
    $display("tb_top failed");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    frame_i = '0;
    timestamp_us_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    prev_angle = '0;
    prev_time = '0;
    awaiting_first = 1'b1;
    est_q8 = 0;
    bad_frames = '0;
    pole_count = POLE_W'(POLES_AT_RESET);
    alpha = ALPHA_W'(ALPHA_AT_RESET);
    mismatch_count = 0;
    steady_flow = 1'b0;
    gen_angle = '0;
    gen_time = '0;
    bad_run = 0;

    // Eleven rejected frames from reset; the eleventh clears the count and flags a burst.
    add_row(16'h0001, 32'h0000_0000, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'h4001, 32'h0000_0000, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'h8000, 32'h0000_0001, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'hC001, 32'h8000_0000, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'h7FFF, 32'h7FFF_FFFF, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'h4000, 32'h0000_0002, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'h0002, 32'h0000_0003, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'hBFFF, 32'h0000_0004, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'h6000, 32'h0000_0005, 1'b1, ST_ERROR, '0, 1'b0);
    add_row(16'h1234, 32'h0000_0006, 1'b1, ST_ERROR, '0, 1'b1);
    // First good sample, then a zero and a negative time step.
    add_row(good_frame(14'd0), 32'd100, 1'b1, ST_FIRST, 14'd0, 1'b0);
    add_row(good_frame(14'd16383), 32'd100, 1'b1, ST_NONPOS, 14'd16383, 1'b0);
    add_row(good_frame(14'd5), 32'd99, 1'b1, ST_NONPOS, 14'd5, 1'b0);
    // Standstill, half turns both ways at the shortest step, and wrapped deltas.
    add_row(good_frame(14'd5), 32'h0000_044B, 1'b0, ST_RPM, '0, 1'b0);
    add_row(good_frame(14'd8197), 32'h0000_044C, 1'b0, ST_RPM, '0, 1'b0);
    add_row(good_frame(14'd5), 32'h0000_044D, 1'b0, ST_RPM, '0, 1'b0);
    add_row(good_frame(14'd8198), 32'h0000_044E, 1'b0, ST_RPM, '0, 1'b0);
    add_row(good_frame(14'd5), 32'h0000_044F, 1'b0, ST_RPM, '0, 1'b0);
    // Largest positive time step, the most negative one, and a step across the wrap.
    add_row(good_frame(14'd7), 32'h8000_0000, 1'b0, ST_RPM, '0, 1'b0);
    add_row(good_frame(14'd16383), 32'hFFFF_FFFF, 1'b0, ST_RPM, '0, 1'b0);
    add_row(good_frame(14'd16383), 32'h7FFF_FFFF, 1'b0, ST_RPM, '0, 1'b0);
    add_row(good_frame(14'd100), 32'h8000_0063, 1'b0, ST_RPM, '0, 1'b0);
    add_row(good_frame(14'd100), 32'h8000_0064, 1'b0, ST_RPM, '0, 1'b0);

    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < stim_table.size(); i++) begin
      send_sample(stim_table[i].frame, stim_table[i].ts, stim_table[i].typed,
                  stim_table[i].want);
    end
    gen_angle = 14'd100;
    gen_time = 32'h8000_0064;

    // Lowest settings: zero pole pairs and a frozen filter.
    apply_settings(16'h0000, 16'h0000);
    send_random_samples(PHASE_LEN);

    // Highest settings, with no idling on either side.
    steady_flow = 1'b1;
    apply_settings(16'hFFFF, 16'hFFFF);
    send_random_samples(PHASE_LEN);
    steady_flow = 1'b0;

    // Random register values, including the unused upper bits of the pole pair write.
    apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    send_random_samples(PHASE_LEN);
    apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    send_random_samples(PHASE_LEN);

    // Few pole pairs, so that raw rpm is large and varied.
    apply_settings(CFG_DATA_W'($urandom_range(7, 1)), CFG_DATA_W'($urandom));
    send_random_samples(PHASE_LEN);

    // Back to the settings after reset.
    apply_settings(CFG_DATA_W'(POLES_AT_RESET), CFG_DATA_W'(ALPHA_AT_RESET));
    send_random_samples(PHASE_LEN);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
